>>> hdl/buddy_block_allocator_macros.svh
// Assertion macros for the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/bba_pkg.sv
// Package for the buddy block allocator: sizes, codes and helpers.
package bba_pkg;
  localparam int MaxOrder  = 12;
  localparam int AddrBits  = 16;
  localparam int NumLists  = MaxOrder + 1;
  localparam int OrdW      = $clog2(NumLists + 1);
  localparam int LinkAw    = AddrBits - 1;
  localparam int LinkDepth = 1 << LinkAw;
  localparam int StepW     = LinkAw + 1;
  localparam logic [StepW-1:0] StepLimit = StepW'(LinkDepth);

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [OrdW-1:0]     ord_t;

  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFree  = 2'd1;
  localparam logic [1:0] OpGrow  = 2'd2;
  localparam logic [1:0] OpBad   = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StOom   = 2'd1;
  localparam logic [1:0] StInval = 2'd2;

  // smallest order >= 1 with 2^order >= bytes; 16 at most for 16-bit sizes
  function automatic logic [4:0] order_for(input logic [15:0] bytes);
    logic [4:0] o;
    o = 5'd16;
    for (int k = 15; k >= 1; k--) begin
      if ((17'd1 << k) >= {1'b0, bytes}) o = 5'(k);
    end
    return o;
  endfunction

  function automatic addr_t bit_of(input ord_t o);
    return addr_t'(1) << o;
  endfunction
endpackage

>>> hdl/buddy_block_allocator.sv
// Buddy block allocator: per-order LIFO free lists with a link memory sequencer.
// Bad requests are answered straight from the check; grow pushes the block at once. Alloc
// searches upward past empty orders, then splits down; free walks the list for the buddy,
// merging until no buddy is found or the top order is reached, then pushes the block.
// Throughput: one item at a time; in_stall is high from accept until the result leaves.
// Reset (rst, synchronous) empties every list; the link memory is not cleared.
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [bba_pkg::AddrBits-1:0] block_addr,
  input  logic [15:0]                 size_bytes,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bba_pkg::AddrBits-1:0] result_addr,
  output logic [1:0]                  status
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_SRCH = 4'd2, S_SPRD = 4'd3,
                         S_SPW1 = 4'd4, S_SPW2 = 4'd5, S_TAKE = 4'd6, S_BUD = 4'd7,
                         S_WALK = 4'd8, S_WRD = 4'd9, S_UNL = 4'd10, S_PUSH = 4'd11,
                         S_OUT = 4'd12, S_UNLRD = 4'd13, S_SPRDW = 4'd14, S_WAIT = 4'd15;

  logic [3:0] state;
  bba_pkg::addr_t heads [bba_pkg::NumLists];
  bba_pkg::addr_t link_mem [bba_pkg::LinkDepth];
  bba_pkg::addr_t rdata;
  logic [1:0] op_r;
  bba_pkg::addr_t addr, blk, prev, cur, tgt;
  logic [4:0] ord_in;
  bba_pkg::ord_t ord, lvl;
  logic at_head;
  logic [bba_pkg::StepW-1:0] steps;
  logic [3:0] ret;

  logic                     we;
  logic [bba_pkg::LinkAw-1:0] waddr, raddr;
  bba_pkg::addr_t            wdata;

  always_ff @(posedge clk) begin
    if (we) link_mem[waddr] <= wdata;
    rdata <= link_mem[raddr];
  end

  function automatic logic [bba_pkg::LinkAw-1:0] lidx(input bba_pkg::addr_t a);
    return a[bba_pkg::AddrBits-1:1];
  endfunction

  assign in_stall = (state != S_IDLE);

  always_comb begin
    we = 1'b0; waddr = lidx(blk); wdata = cur; raddr = lidx(cur);
    unique case (state)
      S_SPRD:  raddr = lidx(blk);
      S_SPW1:  begin we = 1'b1; waddr = lidx(blk); wdata = blk ^ bba_pkg::bit_of(lvl); end
      S_SPW2:  begin we = 1'b1; waddr = lidx(blk ^ bba_pkg::bit_of(lvl));
                     wdata = heads[lvl]; end
      S_TAKE:  raddr = lidx(heads[ord]);
      S_UNLRD: raddr = lidx(cur);
      S_UNL:   begin we = !at_head; waddr = lidx(prev); wdata = rdata; end
      S_PUSH:  begin we = 1'b1; waddr = lidx(addr); wdata = heads[ord]; end
      default: raddr = lidx(cur);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int k = 0; k < bba_pkg::NumLists; k++) heads[k] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          op_r <= op; addr <= block_addr;
          ord_in <= (size_bytes == 16'd0) ? 5'd31 : bba_pkg::order_for(size_bytes);
          result_addr <= '0; status <= bba_pkg::StOk;
          state <= S_CHECK;
        end
        S_CHECK: begin
          ord <= bba_pkg::ord_t'(ord_in);
          lvl <= bba_pkg::ord_t'(ord_in);
          if (op_r == bba_pkg::OpBad || ord_in > 5'(bba_pkg::MaxOrder) ||
              (op_r != bba_pkg::OpAlloc && addr == '0)) begin
            status <= bba_pkg::StInval; state <= S_OUT;
          end else if (op_r == bba_pkg::OpAlloc) state <= S_SRCH;
          else if (op_r == bba_pkg::OpGrow) state <= S_PUSH;
          else state <= S_BUD;
        end
        S_SRCH: begin
          if (heads[lvl] != '0) begin
            if (lvl == ord) state <= S_TAKE;
            else begin blk <= heads[lvl]; state <= S_SPRD; end
          end else if (lvl == bba_pkg::ord_t'(bba_pkg::MaxOrder)) begin
            status <= bba_pkg::StOom; state <= S_OUT;
          end else lvl <= lvl + 1'b1;
        end
        S_SPRD: state <= S_SPRDW;
        S_SPRDW: begin heads[lvl] <= rdata; lvl <= lvl - 1'b1; state <= S_SPW1; end
        S_SPW1: state <= S_SPW2;
        S_SPW2: begin
          heads[lvl] <= blk;
          if (lvl == ord) state <= S_TAKE; else state <= S_SPRD;
        end
        S_TAKE: begin result_addr <= heads[ord]; ret <= S_TAKE; state <= S_WAIT; end
        S_WAIT: begin
          if (ret == S_TAKE) begin heads[ord] <= rdata; state <= S_OUT; end
          else if (ret == S_UNLRD) state <= S_UNL;
          else begin cur <= rdata; steps <= steps + 1'b1; state <= S_WALK; end
        end
        S_BUD: begin
          if (ord == bba_pkg::ord_t'(bba_pkg::MaxOrder)) state <= S_PUSH;
          else begin
            tgt <= addr ^ bba_pkg::bit_of(ord);
            cur <= heads[ord]; prev <= '0; at_head <= 1'b1; steps <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (cur == '0) state <= S_PUSH;
          else if (cur == tgt) state <= S_UNLRD;
          else if (steps >= bba_pkg::StepLimit) state <= S_PUSH;
          else begin prev <= cur; at_head <= 1'b0; ret <= S_WRD; state <= S_WAIT; end
        end
        S_UNLRD: begin ret <= S_UNLRD; state <= S_WAIT; end
        S_UNL: begin
          if (at_head) heads[ord] <= rdata;
          if (tgt < addr) addr <= tgt;
          ord <= ord + 1'b1;
          state <= S_BUD;
        end
        S_PUSH: begin heads[ord] <= addr; state <= S_OUT; end
        S_OUT: begin out_valid <= 1'b1; state <= S_WRD; end
        S_WRD: if (!out_stall) begin out_valid <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BBA_ASSERT_IMP(a_out_idle, out_valid, state == S_WRD, "result shown outside output state")
  `BBA_ASSERT_IMP(a_stall_busy, out_valid, in_stall, "input open while result pending")
  `BBA_ASSERT_IMP(a_oom_zero, out_valid && status != bba_pkg::StOk, result_addr == '0,
                  "failed request returned an address")
  `BBA_ASSERT_NXT(a_accept, in_valid && !in_stall, state == S_CHECK, "accept did not start")
endmodule
